[src/multi_source_bitop_popcount_defines.svh]
// Assertion macros used by the checker file of this block.
`ifndef MULTI_SOURCE_BITOP_POPCOUNT_DEFINES_SVH
`define MULTI_SOURCE_BITOP_POPCOUNT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MSBP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define MSBP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[src/msbp_pkg.sv]
// Types, constants and helper functions of the multi-source bit operation block.
`default_nettype none

package msbp_pkg;

    localparam int unsigned MAX_SOURCES = 16;
    localparam logic [3:0]  WORD_BYTES  = 4'd8;
    localparam logic [4:0]  SRC_CAP     = (MAX_SOURCES < 16) ? 5'(MAX_SOURCES) : 5'd16;

    localparam logic [1:0] OP_AND = 2'd0;
    localparam logic [1:0] OP_OR  = 2'd1;
    localparam logic [1:0] OP_XOR = 2'd2;
    localparam logic [1:0] OP_NOT = 2'd3;

    localparam logic [1:0] REG_OP_KIND     = 2'd0;
    localparam logic [1:0] REG_COUNT_MODE  = 2'd1;
    localparam logic [1:0] REG_NUM_SOURCES = 2'd2;

    localparam logic [31:0] POP_M1 = 32'h5555_5555;
    localparam logic [31:0] POP_M2 = 32'h3333_3333;
    localparam logic [31:0] POP_M4 = 32'h0F0F_0F0F;

    typedef struct packed {
        logic [63:0] source_word;
        logic [3:0]  source_index;
        logic [3:0]  valid_bytes;
        logic        last_word;
    } t_src_word;

    typedef struct packed {
        logic [63:0] result_word;
        logic [3:0]  result_bytes;
        logic [42:0] total;
        logic        is_last;
    } t_result;

    typedef struct packed {
        logic [1:0] op_kind;
        logic       count_mode;
        logic [4:0] num_sources;
    } t_cfg;

    // Classified word as it travels from the front to the back.
    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  nbytes;
        logic        first;
        logic        finish;
        logic        last;
    } t_cls;

    // Finished position waiting for count and totals.
    typedef struct packed {
        logic [63:0] res;
        logic [3:0]  nbytes;
        logic        last;
    } t_fin;

    function automatic logic [63:0] byte_mask(input logic [3:0] nbytes);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            m[b*8 +: 8] = (4'(b) < nbytes) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

    function automatic logic [5:0] pop32(input logic [31:0] v);
        logic [31:0] v1;
        logic [31:0] v2;
        logic [31:0] v3;
        v1 = v - ((v >> 1) & POP_M1);
        v2 = (v1 & POP_M2) + ((v1 >> 2) & POP_M2);
        v3 = (v2 + (v2 >> 4)) & POP_M4;
        return 6'(v3[7:0]) + 6'(v3[15:8]) + 6'(v3[23:16]) + 6'(v3[31:24]);
    endfunction

endpackage

`default_nettype wire

[src/msbp_fifo.sv]
// Small flip-flop queue used between the front and back and at the result side.
`default_nettype none

module msbp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, n_wr;
    logic [PW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

[src/msbp_front.sv]
// Front end: cleans up each source word and marks where its position starts and ends.
`default_nettype none

module msbp_front
    import msbp_pkg::*;
(
    input  wire t_cfg      i_cfg,
    input  wire t_src_word i_src,
    input  wire logic      i_push,
    output t_cls           o_cls,
    output logic           o_keep
);

    logic [4:0] n_eff;
    logic [4:0] idx_ext;
    logic [3:0] vb;

    always_comb begin
        if (i_cfg.num_sources == 5'd0) begin
            n_eff = 5'd1;
        end else if (i_cfg.num_sources > SRC_CAP) begin
            n_eff = SRC_CAP;
        end else begin
            n_eff = i_cfg.num_sources;
        end
        idx_ext = {1'b0, i_src.source_index};
        vb = (i_src.valid_bytes > WORD_BYTES) ? WORD_BYTES : i_src.valid_bytes;

        o_cls.word   = i_src.source_word & byte_mask(vb);
        o_cls.nbytes = vb;
        o_cls.first  = (i_src.source_index == 4'd0);
        o_cls.finish = (idx_ext == n_eff - 5'd1);
        o_cls.last   = i_src.last_word;
        // Words for sources beyond the configured count are dropped here.
        o_keep = i_push && (idx_ext < n_eff);
    end

endmodule

`default_nettype wire

[src/msbp_back.sv]
// Back end: combines words per position, then counts bits and keeps the running totals.
`default_nettype none

module msbp_back
    import msbp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_cfg    i_cfg,
    input  wire t_cls    i_cls,
    input  wire logic    i_cls_empty,
    output logic         o_cls_pop,
    output t_result      o_res,
    output logic         o_res_push,
    input  wire logic    i_res_full
);

    logic [63:0] r_acc, n_acc;
    logic [3:0]  r_pos, n_pos;
    t_fin        r_fin;
    t_fin        n_fin;
    logic        r_fin_vld;
    logic [39:0] r_byte_total, n_byte_total;
    logic [42:0] r_bit_total, n_bit_total;

    logic        adv;
    logic [40:0] byte_sum;
    logic [43:0] bit_sum;
    logic [6:0]  bits;
    logic        emit;

    // The whole back end stalls only when a finished position is held while the result queue is full.
    assign adv       = !(r_fin_vld && i_res_full);
    assign o_cls_pop = adv && !i_cls_empty;

    always_comb begin
        if (i_cls.first) begin
            n_acc = i_cls.word;
            n_pos = i_cls.nbytes;
        end else begin
            n_pos = (i_cls.nbytes > r_pos) ? i_cls.nbytes : r_pos;
            case (i_cfg.op_kind)
                OP_AND:  n_acc = r_acc & i_cls.word;
                OP_OR:   n_acc = r_acc | i_cls.word;
                OP_XOR:  n_acc = r_acc ^ i_cls.word;
                default: n_acc = r_acc;
            endcase
        end
        n_fin.res    = ((i_cfg.op_kind == OP_NOT) ? ~n_acc : n_acc) & byte_mask(n_pos);
        n_fin.nbytes = n_pos;
        n_fin.last   = i_cls.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_pos     <= '0;
            r_fin_vld <= 1'b0;
        end else if (adv) begin
            r_fin_vld <= o_cls_pop && i_cls.finish;
            if (o_cls_pop) begin
                if (i_cls.finish) begin
                    r_acc <= '0;
                    r_pos <= '0;
                end else begin
                    r_acc <= n_acc;
                    r_pos <= n_pos;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && o_cls_pop && i_cls.finish) begin
            r_fin <= n_fin;
        end
    end

    // Second step: bit count and saturating totals of the finished position.
    always_comb begin
        bits     = 7'(pop32(r_fin.res[31:0])) + 7'(pop32(r_fin.res[63:32]));
        byte_sum = {1'b0, r_byte_total} + 41'(r_fin.nbytes);
        bit_sum  = {1'b0, r_bit_total} + 44'(bits);
        n_byte_total = byte_sum[40] ? '1 : byte_sum[39:0];
        n_bit_total  = bit_sum[43] ? '1 : bit_sum[42:0];

        emit       = !i_cfg.count_mode || r_fin.last;
        o_res_push = r_fin_vld && emit;

        o_res.result_word  = i_cfg.count_mode ? 64'd0 : r_fin.res;
        o_res.result_bytes = r_fin.nbytes;
        o_res.is_last      = r_fin.last;
        if (!r_fin.last) begin
            o_res.total = '0;
        end else if (i_cfg.count_mode) begin
            o_res.total = n_bit_total;
        end else begin
            o_res.total = {3'b000, n_byte_total};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_total <= '0;
            r_bit_total  <= '0;
        end else if (adv && r_fin_vld) begin
            if (r_fin.last) begin
                r_byte_total <= '0;
                r_bit_total  <= '0;
            end else begin
                r_byte_total <= n_byte_total;
                r_bit_total  <= n_bit_total;
            end
        end
    end

endmodule

`default_nettype wire

[src/multi_source_bitop_popcount.sv]
// Top level of the multi-source bitwise combine and population count block.
//
// Input side is a queue: drive a source word on i_src and raise push; the word
// is taken on a clock edge where full is low. Words of one position come in
// source order; index 0 opens a position and index num_sources-1 closes it.
// Result side is a queue too: while empty is low the oldest result word sits on
// o_result, and it leaves on an edge where pop is high.
// Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data) with
// op_kind, count_mode and num_sources at indexes 0, 1 and 2; write it while idle.
// Words pass the front queue, then r_fin, then the result queue. Throughput: one
// source word per cycle while the back end is not stalled, set by the single
// combine step; the front queue of QUEUE_DEPTH entries and a two-entry result
// queue absorb stalls. A stalled receiver fills the result queue, then the back
// end holds, then the front queue fills and full rises; nothing is lost.
// Synchronous reset empties both queues, clears the running totals and the
// accumulator, and sets op_kind AND, write mode and one source.
`default_nettype none

module multi_source_bitop_popcount
    import msbp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      push,
    input  wire t_src_word i_src,
    output logic           full,
    output logic           empty,
    input  wire logic      pop,
    output t_result        o_result,
    input  wire logic      i_cfg_we,
    input  wire logic [1:0] i_cfg_idx,
    input  wire logic [4:0] i_cfg_data
);

    t_cfg    r_cfg;
    t_cls    front_cls;
    logic    front_keep;
    logic    cls_full;
    t_cls    cls_head;
    logic    cls_empty;
    logic    cls_pop;
    t_result back_res;
    logic    back_push;
    logic    res_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.op_kind     <= OP_AND;
            r_cfg.count_mode  <= 1'b0;
            r_cfg.num_sources <= 5'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_OP_KIND:     r_cfg.op_kind     <= i_cfg_data[1:0];
                REG_COUNT_MODE:  r_cfg.count_mode  <= i_cfg_data[0];
                REG_NUM_SOURCES: r_cfg.num_sources <= i_cfg_data;
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    assign full = cls_full;

    msbp_front u_front (
        .i_cfg  (r_cfg),
        .i_src  (i_src),
        .i_push (push),
        .o_cls  (front_cls),
        .o_keep (front_keep)
    );

    msbp_fifo #(
        .WIDTH ($bits(t_cls)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cls_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_keep),
        .i_data  (front_cls),
        .o_full  (cls_full),
        .i_pop   (cls_pop),
        .o_data  (cls_head),
        .o_empty (cls_empty)
    );

    msbp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cls       (cls_head),
        .i_cls_empty (cls_empty),
        .o_cls_pop   (cls_pop),
        .o_res       (back_res),
        .o_res_push  (back_push),
        .i_res_full  (res_full)
    );

    msbp_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (back_push),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

endmodule

`default_nettype wire

[src/msbp_checker.sv]
// Port-level checker for the multi-source bit operation block, bound to its top level.
`default_nettype none
`include "multi_source_bitop_popcount_defines.svh"

module msbp_checker
    import msbp_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      full,
    input wire logic      empty,
    input wire logic      pop,
    input wire t_result   o_result
);

    // Both queues come out of reset empty.
    `MSBP_ASSERT_IMP(a_reset_clean, $past(!i_rst_n), empty && !full)

    // A waiting result word holds until it is popped.
    `MSBP_ASSERT_NXT(a_hold, !empty && !pop, !empty && $stable(o_result))

    // Only the final word of a stream carries a total.
    `MSBP_ASSERT_IMP(a_total_last, !empty && !o_result.is_last, o_result.total == 43'd0)

    // A result never claims more bytes than one word holds.
    `MSBP_ASSERT_IMP(a_bytes_range, !empty, o_result.result_bytes <= WORD_BYTES)

endmodule

bind multi_source_bitop_popcount msbp_checker u_msbp_checker (.*);

`default_nettype wire

[sim/tb_multi_source_bitop_popcount.sv]
// Self-checking testbench for the multi-source bitwise combine and popcount block.
`default_nettype none

module tb_multi_source_bitop_popcount
    import msbp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0]  REG_UNUSED    = 2'd3;
    localparam int          PHASE_ITEMS   = 90;
    localparam int          COUNT_STREAMS = 24;
    localparam int          DRAIN_CYCLES  = 20;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          QUIET_LIMIT   = 3000;
    localparam int          MAX_REPORTS   = 10;
    localparam logic [63:0] BYTE_SUM_MAX  = (64'd1 << 40) - 64'd1;
    localparam logic [63:0] BIT_SUM_MAX   = (64'd1 << 43) - 64'd1;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        push       = 1'b0;
    t_src_word   i_src      = '0;
    logic        full;
    logic        empty;
    logic        pop        = 1'b0;
    t_result     o_result;
    logic        i_cfg_we   = 1'b0;
    logic [1:0]  i_cfg_idx  = '0;
    logic [4:0]  i_cfg_data = '0;

    // Configuration and running state of the predictor.
    logic [1:0]  cfg_op    = OP_AND;
    logic        cfg_count = 1'b0;
    logic [4:0]  cfg_nsrc  = 5'd1;
    logic [63:0] acc_word  = '0;
    logic [3:0]  acc_bytes = '0;
    logic [63:0] bytes_sum = '0;
    logic [63:0] bits_sum  = '0;

    t_src_word   words_to_send[$];
    t_result     results_due[$];

    int          send_idle_pct   = 0;
    int          recv_stall_pct  = 0;
    bit          long_hold_armed = 1'b0;
    bit          hold_started    = 1'b0;
    int          hold_left       = 0;
    int          mismatches      = 0;
    int          gen_count       = 0;
    int          quiet_cycles    = 0;

    multi_source_bitop_popcount dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .i_src      (i_src),
        .full       (full),
        .empty      (empty),
        .pop        (pop),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic int active_sources();
        if (cfg_nsrc == 5'd0) return 1;
        if (cfg_nsrc > SRC_CAP) return int'(SRC_CAP);
        return int'(cfg_nsrc);
    endfunction

    function automatic logic [63:0] lane_mask(input logic [3:0] nbytes);
        if (nbytes >= 4'd8) return '1;
        return (64'd1 << (nbytes * 8)) - 64'd1;
    endfunction

    // Folds one accepted word into the current position and queues the
    // result word that the position produces, if any.
    task automatic combine_word(input t_src_word w);
        logic [3:0]  vb;
        logic [63:0] data;
        logic [63:0] res;
        logic [3:0]  nb;
        int          n;
        t_result     r;
        vb = (w.valid_bytes > WORD_BYTES) ? WORD_BYTES : w.valid_bytes;
        n  = active_sources();
        if (int'(w.source_index) >= n) return;
        data = w.source_word & lane_mask(vb);
        if (w.source_index == 4'd0) begin
            acc_word  = data;
            acc_bytes = vb;
        end else begin
            if (vb > acc_bytes) acc_bytes = vb;
            case (cfg_op)
                OP_AND: acc_word &= data;
                OP_OR:  acc_word |= data;
                OP_XOR: acc_word ^= data;
                default: ;
            endcase
        end
        if (int'(w.source_index) != n - 1) return;
        nb  = acc_bytes;
        res = ((cfg_op == OP_NOT) ? ~acc_word : acc_word) & lane_mask(nb);
        bytes_sum = (bytes_sum + nb > BYTE_SUM_MAX) ? BYTE_SUM_MAX : bytes_sum + nb;
        bits_sum  = (bits_sum + $countones(res) > BIT_SUM_MAX) ? BIT_SUM_MAX
                                                               : bits_sum + $countones(res);
        acc_word  = '0;
        acc_bytes = '0;
        if (cfg_count && !w.last_word) return;
        r.result_word  = cfg_count ? 64'd0 : res;
        r.result_bytes = nb;
        r.total        = w.last_word ? (cfg_count ? bits_sum[42:0] : bytes_sum[42:0]) : '0;
        r.is_last      = w.last_word;
        results_due.push_back(r);
        if (w.last_word) begin
            bytes_sum = '0;
            bits_sum  = '0;
        end
    endtask

    // Sender: holds a word on the port until it is taken.
    always @(posedge i_clk) begin : drive_words
        logic      push_nx;
        t_src_word src_nx;
        push_nx = push;
        src_nx  = i_src;
        if (!i_rst_n) begin
            push_nx = 1'b0;
        end else begin
            if (push && !full) begin
                combine_word(i_src);
                words_to_send.delete(0);
                push_nx = 1'b0;
            end
            if (!push_nx && words_to_send.size() != 0 &&
                $urandom_range(99) >= send_idle_pct) begin
                push_nx = 1'b1;
                src_nx  = words_to_send[0];
            end
        end
        push  <= push_nx;
        i_src <= src_nx;
    end

    // Receiver: checks each word taken against the oldest expected one.
    always @(posedge i_clk) begin : take_results
        logic    pop_nx;
        t_result want;
        pop_nx = 1'b0;
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (results_due.size() == 0) begin
                    if (mismatches < MAX_REPORTS)
                        $display("unexpected result: word %h bytes %0d total %0d last %0b",
                                 o_result.result_word, o_result.result_bytes,
                                 o_result.total, o_result.is_last);
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    if (o_result.result_word !== want.result_word ||
                        o_result.result_bytes !== want.result_bytes ||
                        o_result.total !== want.total ||
                        o_result.is_last !== want.is_last) begin
                        if (mismatches < MAX_REPORTS) begin
                            $display("mismatch: expected word %h bytes %0d total %0d last %0b",
                                     want.result_word, want.result_bytes,
                                     want.total, want.is_last);
                            $display("          actual   word %h bytes %0d total %0d last %0b",
                                     o_result.result_word, o_result.result_bytes,
                                     o_result.total, o_result.is_last);
                        end
                        mismatches++;
                    end
                end
            end
            if (long_hold_armed && !hold_started) begin
                hold_started = 1'b1;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) hold_left--;
            else pop_nx = ($urandom_range(99) >= recv_stall_pct);
        end
        pop <= pop_nx;
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("FAIL");
        $finish;
    end

    task automatic write_reg(input logic [1:0] idx, input logic [4:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Unused upper data bits carry random values; the block must mask them.
    task automatic set_cfg(input logic [1:0] op, input logic cnt, input logic [4:0] nsrc);
        logic [4:0] d;
        d = 5'($urandom);
        d[1:0] = op;
        write_reg(REG_OP_KIND, d);
        d = 5'($urandom);
        d[0] = cnt;
        write_reg(REG_COUNT_MODE, d);
        write_reg(REG_NUM_SOURCES, nsrc);
        write_reg(REG_UNUSED, 5'($urandom));
        cfg_op    = op;
        cfg_count = cnt;
        cfg_nsrc  = nsrc;
    endtask

    task automatic wait_idle();
        while (words_to_send.size() != 0 || push || results_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic add_word(input logic [63:0] w, input int idx, input int vb, input bit last);
        t_src_word s;
        s.source_word  = w;
        s.source_index = idx[3:0];
        s.valid_bytes  = vb[3:0];
        s.last_word    = last;
        words_to_send.push_back(s);
        if (int'(s.source_index) < active_sources()) gen_count++;
    endtask

    function automatic logic [63:0] rand_word();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return 64'd1 << $urandom_range(63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic int rand_vb();
        if ($urandom_range(9) == 0) return $urandom_range(15, 9);
        return $urandom_range(8);
    endfunction

    // One position in source order; a noisy one mixes in skipped, repeated,
    // stray and restarting words and stray final marks.
    task automatic add_position(input int n, input bit fin);
        bit noisy;
        int r;
        noisy = ($urandom_range(4) == 0);
        for (int i = 0; i < n; i++) begin
            r = noisy ? $urandom_range(7) : 7;
            if (r == 2) add_word(rand_word(), $urandom_range(15), rand_vb(),
                                 1'($urandom_range(1)));
            if (r == 3 && i > 0) add_word(rand_word(), 0, rand_vb(), 1'b0);
            if (r == 0 && i != n - 1) continue;
            if (r == 1) add_word(rand_word(), i, rand_vb(), noisy && $urandom_range(1));
            add_word(rand_word(), i, rand_vb(), (i == n - 1) ? fin : (noisy && $urandom_range(1)));
        end
    endtask

    task automatic run_random(input logic [1:0] op, input logic cnt, input logic [4:0] nsrc,
                              input int send_pct, input int stall_pct, input bit hold);
        int streams;
        int npos;
        int n;
        wait_idle();
        set_cfg(op, cnt, nsrc);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        n         = active_sources();
        gen_count = 0;
        streams   = 0;
        while (gen_count < PHASE_ITEMS || (cnt && streams < COUNT_STREAMS)) begin
            npos = cnt ? $urandom_range(3, 1) : $urandom_range(6, 1);
            for (int p = 0; p < npos; p++) add_position(n, p == npos - 1);
            streams++;
        end
        if (hold) long_hold_armed = 1'b1;
    endtask

    initial begin : main
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: AND, write mode, one source.
        add_word('1, 0, 8, 1'b0);
        add_word('1, 0, 15, 1'b1);
        add_word('0, 0, 0, 1'b1);
        add_word('1, 5, 8, 1'b1);

        wait_idle();
        set_cfg(OP_OR, 1'b0, 5'd3);
        add_word(64'h0123_4567_89AB_CDEF, 0, 3, 1'b0);
        add_word(64'hF0F0_0000_0F0F_1000, 1, 8, 1'b0);
        add_word(64'h8000_0000_0000_0001, 2, 5, 1'b1);
        // A word with index zero drops the unfinished position.
        add_word('1, 0, 8, 1'b0);
        add_word('1, 1, 8, 1'b0);
        add_word(64'h0000_0000_0000_00A5, 0, 1, 1'b0);
        add_word(64'h0000_0000_0000_5A00, 2, 2, 1'b0);
        add_word(64'h1111_2222_3333_4444, 0, 8, 1'b0);
        add_word(64'h5555_6666_7777_8888, 2, 6, 1'b0);
        // Only the final mark of the closing word counts.
        add_word(64'hDEAD_BEEF_CAFE_F00D, 0, 8, 1'b1);
        add_word(64'h0BAD_F00D_0000_FFFF, 1, 4, 1'b1);
        add_word(64'h0000_0000_0000_0000, 2, 0, 1'b0);
        add_word(64'h0000_00FF_0000_00FF, 1, 7, 1'b0);
        add_word(64'hFF00_0000_FF00_0000, 1, 8, 1'b0);
        add_word(64'h0000_0000_0000_0001, 2, 1, 1'b1);

        // NOT widens to the longest source and inverts padding to ones.
        wait_idle();
        set_cfg(OP_NOT, 1'b0, 5'd2);
        add_word(64'h0000_0000_0000_0F0F, 0, 2, 1'b0);
        add_word('0, 1, 7, 1'b1);

        wait_idle();
        set_cfg(OP_XOR, 1'b1, 5'd2);
        add_word('1, 0, 8, 1'b0);
        add_word(64'h0000_0000_1234_5678, 1, 4, 1'b0);
        add_word(64'hFFFF_0000_FFFF_0000, 0, 8, 1'b0);
        add_word(64'h0F0F_0F0F_0F0F_0F0F, 1, 8, 1'b1);

        run_random(OP_AND, 1'b0, 5'd4,  0,  0,  1'b1);
        run_random(OP_OR,  1'b0, 5'd1,  52, 0,  1'b0);
        run_random(OP_XOR, 1'b1, 5'd5,  0,  52, 1'b0);
        run_random(OP_NOT, 1'b0, 5'd3,  22, 22, 1'b0);
        run_random(OP_AND, 1'b1, 5'd0,  0,  0,  1'b0);
        run_random(OP_XOR, 1'b0, 5'd31, 52, 0,  1'b0);
        run_random(OP_NOT, 1'b1, 5'd2,  0,  52, 1'b0);
        run_random(OP_OR,  1'b0, 5'd16, 22, 22, 1'b0);
        run_random(OP_NOT, 1'b0, 5'd9,  22, 22, 1'b0);

        wait_idle();
        if (results_due.size() != 0) mismatches++;
        if (mismatches == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
+incdir+src
src/msbp_pkg.sv
src/msbp_fifo.sv
src/msbp_front.sv
src/msbp_back.sv
src/multi_source_bitop_popcount.sv
src/msbp_checker.sv
sim/tb_multi_source_bitop_popcount.sv
